// ===== rtl/json_comment_stripper_macros.svh =====
// assertion macros for the comment stripper rtl
`ifndef JSON_COMMENT_STRIPPER_MACROS_SVH
`define JSON_COMMENT_STRIPPER_MACROS_SVH

// checked property, ignored while reset is high
`define JCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also checked through reset
`define JCS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/jcs_pkg.sv =====
// types and constants for the comment stripper
package jcs_pkg;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;

   // result queue depth, a power of two
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
   } rsp_type;

   typedef enum logic [6:0] {
      MODE_PLAIN = 7'b0000001,
      MODE_SLASH = 7'b0000010,
      MODE_STR   = 7'b0000100,
      MODE_ESC   = 7'b0001000,
      MODE_LINE  = 7'b0010000,
      MODE_BLOCK = 7'b0100000,
      MODE_BSTAR = 7'b1000000
   } mode_type;

endpackage

// ===== rtl/json_comment_stripper.sv =====
// top level of the streaming comment stripper
//
//  channel | direction | ports                           | payload
//  request | in        | req_valid, req_stall, req_data  | in_byte, in_last
//  result  | out       | rsp_valid, rsp_stall, rsp_data  | out_byte, has_byte, out_last
//
// one request is taken per cycle unless req_stall is high; its results (0 to 2)
// are known in the same cycle and land in a four-entry result queue, drained
// one per cycle unless rsp_stall is high. req_stall comes from the registered
// queue count alone: it rises when more than two results wait, so a request
// yielding two results slows input to the output rate of one result per cycle.
// synchronous reset empties the queue and returns the scanner to plain text.
module json_comment_stripper #(
   parameter int unsigned QueueDepth = jcs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jcs_pkg::rsp_type rsp_data
);

`include "json_comment_stripper_macros.svh"

   localparam int unsigned PTR_W = $clog2(QueueDepth);
   localparam int unsigned CNT_W = $clog2(QueueDepth + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QueueDepth - 2);

   jcs_pkg::mode_type mode_ff, mode_in;
   jcs_pkg::mode_type mode_mid;
   jcs_pkg::rsp_type  queue_ff [QueueDepth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic             req_take;
   logic             rsp_take;
   logic [7:0]       b;
   logic [1:0]       n_mid;
   logic [1:0]       n_out;
   jcs_pkg::rsp_type slot0, slot1;

   // handshakes
   assign req_stall = (count_ff > ROOM_LIMIT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign b         = req_data.in_byte;

   // scan one byte: mode step, kept bytes, end of stream handling
   always_comb begin
      mode_mid = mode_ff;
      n_mid    = 2'd0;
      slot0    = '{out_byte: b, has_byte: 1'b1, out_last: 1'b0};
      slot1    = '{out_byte: b, has_byte: 1'b1, out_last: 1'b0};
      case (mode_ff)
         jcs_pkg::MODE_SLASH: begin
            if (b == jcs_pkg::CH_SLASH) begin
               mode_mid = jcs_pkg::MODE_LINE;
            end else if (b == jcs_pkg::CH_STAR) begin
               mode_mid = jcs_pkg::MODE_BLOCK;
            end else begin
               // held slash goes out first, then the byte as plain text
               slot0.out_byte = jcs_pkg::CH_SLASH;
               n_mid          = 2'd1;
               mode_mid       = jcs_pkg::MODE_PLAIN;
               if (b == jcs_pkg::CH_QUOTE) begin
                  mode_mid = jcs_pkg::MODE_STR;
               end
               n_mid = 2'd2;
            end
         end
         jcs_pkg::MODE_STR: begin
            n_mid = 2'd1;
            if (b == jcs_pkg::CH_QUOTE) begin
               mode_mid = jcs_pkg::MODE_PLAIN;
            end else if (b == jcs_pkg::CH_BSLASH) begin
               mode_mid = jcs_pkg::MODE_ESC;
            end
         end
         jcs_pkg::MODE_ESC: begin
            n_mid    = 2'd1;
            mode_mid = jcs_pkg::MODE_STR;
         end
         jcs_pkg::MODE_LINE: begin
            if (b == jcs_pkg::CH_NL) begin
               n_mid    = 2'd1;
               mode_mid = jcs_pkg::MODE_PLAIN;
            end
         end
         jcs_pkg::MODE_BLOCK: begin
            if (b == jcs_pkg::CH_STAR) begin
               mode_mid = jcs_pkg::MODE_BSTAR;
            end
         end
         jcs_pkg::MODE_BSTAR: begin
            if (b == jcs_pkg::CH_SLASH) begin
               mode_mid = jcs_pkg::MODE_PLAIN;
            end else if (b != jcs_pkg::CH_STAR) begin
               mode_mid = jcs_pkg::MODE_BLOCK;
            end
         end
         default: begin
            // plain text, and any stray code
            if (b == jcs_pkg::CH_SLASH) begin
               mode_mid = jcs_pkg::MODE_SLASH;
            end else begin
               n_mid    = 2'd1;
               mode_mid = jcs_pkg::MODE_PLAIN;
               if (b == jcs_pkg::CH_QUOTE) begin
                  mode_mid = jcs_pkg::MODE_STR;
               end
            end
         end
      endcase

      mode_in = mode_mid;
      n_out   = n_mid;
      if (req_data.in_last) begin
         // flush a held slash, or add a bare end marker
         if (mode_mid == jcs_pkg::MODE_SLASH) begin
            if (n_mid == 2'd0) begin
               slot0.out_byte = jcs_pkg::CH_SLASH;
            end else begin
               slot1.out_byte = jcs_pkg::CH_SLASH;
            end
            n_out = n_mid + 2'd1;
         end else if (n_mid == 2'd0) begin
            slot0 = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b0};
            n_out = 2'd1;
         end
         if (n_out == 2'd2) begin
            slot1.out_last = 1'b1;
         end else begin
            slot0.out_last = 1'b1;
         end
         mode_in = jcs_pkg::MODE_PLAIN;
      end
   end

   // queue pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(n_out);
         count_in  = count_in + CNT_W'(n_out);
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= jcs_pkg::MODE_PLAIN;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_take) begin
            mode_ff <= mode_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (req_take && (n_out != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (req_take && (n_out == 2'd2)) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= slot1;
      end
   end

   `JCS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QueueDepth),
      "result queue count beyond depth")
   `JCS_ASSERT(a_take_has_room, clock, reset, req_take |-> count_ff <= ROOM_LIMIT,
      "request taken without room for two results")
   `JCS_ASSERT(a_last_to_plain, clock, reset,
      (req_take && req_data.in_last) |=> mode_ff == jcs_pkg::MODE_PLAIN,
      "scanner not back in plain text after end of stream")
   `JCS_ASSERT_NR(a_reset_empty, clock, $past(reset) |-> count_ff == '0,
      "result queue not empty after reset")

endmodule
